// ----- sv/pdc_pkg.sv -----
`default_nettype none

package pdc_pkg;

    // Field widths fixed by the request and message formats
    localparam int NODE_CNT_W = 5;
    localparam int PAGE_W     = 10;
    localparam int NODE_W     = 4;

    // Defaults for the top-level parameters
    localparam int PAGES_DEF = 1024;
    localparam int NODES_DEF = 16;

    // Reset value of the node count register
    localparam logic [NODE_CNT_W-1:0] NODE_COUNT_RESET = 5'd16;

    // Depth of the command queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 2;

    // Page modes
    localparam logic MODE_SHARED   = 1'b0;
    localparam logic MODE_WRITABLE = 1'b1;

    // Request kinds on the input stream
    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_CLAIM = 2'd2,
        ACT_BAD   = 2'd3
    } action_t;

    // Classified command handed from front to back
    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_CLAIM  = 2'd2,
        OP_REJECT = 2'd3
    } op_t;

    // Message kinds on the output stream
    typedef enum logic [2:0] {
        MSG_FETCH      = 3'd0,
        MSG_INVALIDATE = 3'd1,
        MSG_REVOKE     = 3'd2,
        MSG_GRANT      = 3'd3,
        MSG_REPLY      = 3'd4,
        MSG_REJECT     = 3'd5
    } msg_kind_t;

    typedef struct packed {
        op_t               op;
        logic [PAGE_W-1:0] page;
        logic [NODE_W-1:0] req;
    } cmd_t;

    typedef struct packed {
        msg_kind_t         kind;
        logic [NODE_W-1:0] target_node;
        logic [PAGE_W-1:0] page_index;
        logic              grants_write;
        logic [NODE_W-1:0] data_from;
        logic              data_valid;
        logic              last;
    } msg_t;

    // Status from the back end to the front end
    typedef struct packed {
        logic clearing;
        logic pop;
    } back_status_t;

endpackage

`default_nettype wire

// ----- sv/page_directory_coherence.sv -----
// Channel    Signals                          Fields (lowest bit first)
// ---------  -------------------------------  ----------------------------------------
// request    s_axis_tvalid/tready/tdata/tuser tuser: action; tdata: page, requester
// message    m_axis_tvalid/tready/tdata/tuser tuser: message_kind; tdata: target_node,
//            /tlast                           page_index, grants_write, data_from,
//                                             data_valid; tlast: last
// config     cfg_wr_en/cfg_wr_data            node_count
//
// The back end scans one node per cycle and sends one message per cycle while the message
// output is not stalled. After reset a clearing pass writes every directory entry, with
// requests held off; config writes are taken throughout.
// A two-entry request queue lets the front accept while the back is busy or stalled on
// the message output, which is a single output register.
`default_nettype none

module page_directory_coherence
    import pdc_pkg::*;
#(
    parameter int PAGES = PAGES_DEF,
    parameter int NODES = NODES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [15:0]           s_axis_tdata,  // page[9:0], requester[13:10]
    input  wire logic [1:0]            s_axis_tuser,  // action[1:0]
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [23:0]                m_axis_tdata,  // target_node[3:0], page_index[13:4],
                                                      // grants_write[14], data_from[18:15],
                                                      // data_valid[19]
    output logic [2:0]                 m_axis_tuser,  // message_kind[2:0]
    output logic                       m_axis_tlast,
    input  wire logic                  cfg_wr_en,
    input  wire logic [NODE_CNT_W-1:0] cfg_wr_data
);

    localparam logic [6:0] NODES_C = 7'(NODES);

    logic [NODE_CNT_W-1:0] node_count_reg;
    logic [NODE_CNT_W-1:0] eff_count;
    cmd_t                  cmd;
    logic                  cmd_valid;
    back_status_t          status;
    msg_t                  msg;

    // Node count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            node_count_reg <= cfg_wr_data;
        end
    end

    // Counts above the node parameter act as the parameter
    assign eff_count = ({2'b0, node_count_reg} > NODES_C) ? NODES_C[NODE_CNT_W-1:0]
                                                          : node_count_reg;

    pdc_front #(
        .PAGES (PAGES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .eff_count     (eff_count),
        .status        (status),
        .cmd           (cmd),
        .cmd_valid     (cmd_valid)
    );

    pdc_back #(
        .PAGES (PAGES),
        .NODES (NODES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .eff_count (eff_count),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_msg   (msg)
    );

    // Message packing
    assign m_axis_tdata = {4'b0, msg.data_valid, msg.data_from, msg.grants_write,
                           msg.page_index, msg.target_node};
    assign m_axis_tuser = msg.kind;
    assign m_axis_tlast = msg.last;

    // Checks
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> !s_axis_tready)
        else $error("request accepted during clearing pass");

    a_reject_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && msg.kind == MSG_REJECT) |-> msg.last)
        else $error("reject not marked last");

    a_write_flag_on_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && msg.grants_write) |-> (msg.kind == MSG_GRANT))
        else $error("write flag on a non-grant message");

    a_data_on_grant_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && msg.data_valid)
            |-> (msg.kind == MSG_GRANT || msg.kind == MSG_REPLY))
        else $error("data marked valid on wrong message kind");

endmodule

`default_nettype wire

// ----- sv/pdc_ram.sv -----
`default_nettype none

module pdc_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/pdc_front.sv -----
`default_nettype none

module pdc_front
    import pdc_pkg::*;
#(
    parameter int PAGES = PAGES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [15:0]           s_axis_tdata,
    input  wire logic [1:0]            s_axis_tuser,
    input  wire logic [NODE_CNT_W-1:0] eff_count,
    input  wire back_status_t          status,
    output cmd_t                       cmd,
    output logic                       cmd_valid
);

    localparam int QPW = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [16:0] PAGE_LIMIT = 17'(PAGES);

    cmd_t            q_mem_reg [QUEUE_DEPTH];
    logic [QPW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]  q_count_reg, q_count_next;

    action_t           action;
    logic [PAGE_W-1:0] page;
    logic [NODE_W-1:0] requester;
    logic              reject;
    cmd_t              new_cmd;
    logic              push;

    // Unpack and classify the incoming request
    always_comb
    begin
        action    = action_t'(s_axis_tuser);
        page      = s_axis_tdata[PAGE_W-1:0];
        requester = s_axis_tdata[PAGE_W+NODE_W-1:PAGE_W];
        reject    = (action == ACT_BAD)
                 || ({1'b0, requester} >= eff_count)
                 || ({7'b0, page} >= PAGE_LIMIT);
        new_cmd.page = page;
        new_cmd.req  = requester;
        if (reject)
        begin
            new_cmd.op = OP_REJECT;
        end
        else
        begin
            case (action)
                ACT_READ:  new_cmd.op = OP_READ;
                ACT_WRITE: new_cmd.op = OP_WRITE;
                ACT_CLAIM: new_cmd.op = OP_CLAIM;
                default:   new_cmd.op = OP_REJECT;
            endcase
        end
    end

    // Queue control
    assign s_axis_tready = !status.clearing && (q_count_reg != QCW'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign cmd_valid     = (q_count_reg != '0);
    assign cmd           = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next  = push ? wr_ptr_reg + QPW'(1) : wr_ptr_reg;
        rd_ptr_next  = status.pop ? rd_ptr_reg + QPW'(1) : rd_ptr_reg;
        q_count_next = q_count_reg;
        if (push && !status.pop)
        begin
            q_count_next = q_count_reg + QCW'(1);
        end
        else if (!push && status.pop)
        begin
            q_count_next = q_count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            q_count_reg <= q_count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- sv/pdc_back.sv -----
`default_nettype none

module pdc_back
    import pdc_pkg::*;
#(
    parameter int PAGES = PAGES_DEF,
    parameter int NODES = NODES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    input  wire logic                  cmd_valid,
    input  wire logic [NODE_CNT_W-1:0] eff_count,
    output back_status_t               status,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output msg_t                       out_msg
);

    localparam int AW = PAGES > 1 ? $clog2(PAGES) : 1;
    localparam int DW = NODES + 1;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_LOAD   = 8'b0000_0100,
        S_WSCAN  = 8'b0000_1000,
        S_RSCAN  = 8'b0001_0000,
        S_GRANT  = 8'b0010_0000,
        S_REPLY  = 8'b0100_0000,
        S_REJECT = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         clr_addr_reg;
    logic                  out_valid_reg;
    msg_t                  out_msg_reg;

    cmd_t                  cmd_reg;
    logic [NODES-1:0]      scan_bits_reg;
    logic [NODES-1:0]      held_reg;
    logic                  mode_reg;
    logic [NODE_CNT_W-1:0] idx_reg;
    logic                  have_reg;
    logic [NODE_W-1:0]     from_reg;

    logic                  slot_free;
    logic                  pop;
    logic                  emit;
    msg_t                  emit_msg;
    logic                  advance;
    logic                  set_have;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DW-1:0]         ram_wdata;
    logic [DW-1:0]         ram_rdata;
    logic [NODES-1:0]      req_onehot;

    assign slot_free  = !out_valid_reg || out_ready;
    assign req_onehot = NODES'(1) << cmd_reg.req;

    assign status.clearing = (state_reg == S_CLEAR);
    assign status.pop      = pop;
    assign out_valid       = out_valid_reg;
    assign out_msg         = out_msg_reg;

    // Directory memory: {mode, holder bits} per page
    pdc_ram #(
        .WIDTH (DW),
        .DEPTH (PAGES)
    ) u_dir (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (AW'(cmd.page)),
        .rdata (ram_rdata)
    );

    // Sequencer: one message per cycle at most
    always_comb
    begin
        state_next            = state_reg;
        pop                   = 1'b0;
        emit                  = 1'b0;
        emit_msg              = '0;
        emit_msg.page_index   = cmd_reg.page;
        emit_msg.target_node  = cmd_reg.req;
        advance               = 1'b0;
        set_have              = 1'b0;
        ram_we                = 1'b0;
        ram_waddr             = AW'(cmd_reg.page);
        ram_wdata             = '0;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                if (clr_addr_reg == AW'(PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    pop = 1'b1;
                    case (cmd.op)
                        OP_REJECT: state_next = S_REJECT;
                        OP_CLAIM:  state_next = S_GRANT;
                        default:   state_next = S_LOAD;
                    endcase
                end
            end
            S_LOAD:
            begin
                state_next = (cmd_reg.op == OP_WRITE) ? S_WSCAN : S_RSCAN;
            end
            // Write: fetch from first other holder, invalidate every other node
            S_WSCAN:
            begin
                emit_msg.target_node = idx_reg[NODE_W-1:0];
                if (idx_reg == eff_count)
                begin
                    state_next = S_GRANT;
                end
                else if (idx_reg == {1'b0, cmd_reg.req})
                begin
                    advance = 1'b1;
                end
                else if (slot_free)
                begin
                    emit = 1'b1;
                    if (!have_reg && scan_bits_reg[0])
                    begin
                        emit_msg.kind = MSG_FETCH;
                        set_have      = 1'b1;
                    end
                    else
                    begin
                        emit_msg.kind = MSG_INVALIDATE;
                        advance       = 1'b1;
                    end
                end
            end
            // Read: fetch or revoke at the first holder
            S_RSCAN:
            begin
                emit_msg.target_node = idx_reg[NODE_W-1:0];
                emit_msg.kind = (mode_reg == MODE_SHARED) ? MSG_FETCH : MSG_REVOKE;
                if (idx_reg == eff_count)
                begin
                    state_next = S_REPLY;
                end
                else if (scan_bits_reg[0])
                begin
                    if (slot_free)
                    begin
                        emit       = 1'b1;
                        set_have   = 1'b1;
                        state_next = S_REPLY;
                    end
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            S_GRANT:
            begin
                emit_msg.kind         = MSG_GRANT;
                emit_msg.grants_write = (cmd_reg.op == OP_WRITE);
                emit_msg.data_from    = from_reg;
                emit_msg.data_valid   = have_reg;
                emit_msg.last         = (cmd_reg.op == OP_CLAIM);
                if (slot_free)
                begin
                    emit = 1'b1;
                    if (cmd_reg.op == OP_CLAIM)
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = {MODE_SHARED, req_onehot};
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_REPLY;
                    end
                end
            end
            S_REPLY:
            begin
                emit_msg.kind       = MSG_REPLY;
                emit_msg.data_from  = from_reg;
                emit_msg.data_valid = have_reg;
                emit_msg.last       = 1'b1;
                if (cmd_reg.op == OP_WRITE)
                begin
                    ram_wdata = {MODE_WRITABLE, req_onehot};
                end
                else
                begin
                    ram_wdata = {MODE_SHARED, held_reg | req_onehot};
                end
                if (slot_free)
                begin
                    emit       = 1'b1;
                    ram_we     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_REJECT:
            begin
                emit_msg.kind = MSG_REJECT;
                emit_msg.last = 1'b1;
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the current request
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_msg_reg <= emit_msg;
        end
        if (pop)
        begin
            cmd_reg  <= cmd;
            idx_reg  <= '0;
            have_reg <= 1'b0;
            from_reg <= '0;
        end
        if (state_reg == S_LOAD)
        begin
            scan_bits_reg <= ram_rdata[NODES-1:0];
            held_reg      <= ram_rdata[NODES-1:0];
            mode_reg      <= ram_rdata[NODES];
        end
        if (advance)
        begin
            idx_reg       <= idx_reg + NODE_CNT_W'(1);
            scan_bits_reg <= scan_bits_reg >> 1;
        end
        if (set_have)
        begin
            have_reg <= 1'b1;
            from_reg <= idx_reg[NODE_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
module tb;
    import pdc_pkg::*;

    localparam int PAGE_COUNT    = PAGES_DEF;
    localparam int NODE_MAX      = NODES_DEF;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOT_PAGES     = 8;

    // Receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_HALF,
        RX_SPARSE
    } rx_pattern_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata = '0;  // page[9:0], requester[13:10]
    logic [1:0]            s_axis_tuser = '0;  // action[1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;       // target[3:0], page[13:4], grants_write[14],
                                               // data_from[18:15], data_valid[19]
    logic [2:0]            m_axis_tuser;       // message_kind[2:0]
    logic                  m_axis_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [NODE_CNT_W-1:0] cfg_wr_data = '0;

    page_directory_coherence uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #5 clk = ~clk;

    // Directory copy kept by the testbench
    logic [NODE_MAX-1:0]   dir_holders [PAGE_COUNT];
    logic                  dir_mode [PAGE_COUNT];
    logic [NODE_CNT_W-1:0] node_limit = NODE_COUNT_RESET;
    msg_t                  pending_msgs [$];

    int          mismatch_count = 0;
    int          burst_left = 0;
    bit          sender_steady = 1'b0;
    logic [9:0]  hot_pages [HOT_PAGES];

    // Receiver state: stall pattern and long hold-off
    int unsigned holdoff_requested = 0;
    int unsigned holdoff_taken = 0;
    int          holdoff_len = 0;
    int          holdoff_left = 0;
    int          pattern_left = 0;
    rx_pattern_t pattern_kind = RX_OPEN;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic msg_t build_msg(msg_kind_t kind, int target, logic [PAGE_W-1:0] pg,
                                       logic gw, int from, logic dv, logic fin);
        msg_t m;
        m.kind         = kind;
        m.target_node  = NODE_W'(target);
        m.page_index   = pg;
        m.grants_write = gw;
        m.data_from    = NODE_W'(from);
        m.data_valid   = dv;
        m.last         = fin;
        return m;
    endfunction

    // Append one expected message at the tail of the queue
    function automatic void add_expected(msg_t m);
        pending_msgs.insert(pending_msgs.size(), m);
    endfunction

    function automatic int active_nodes();
        return (node_limit > NODE_MAX) ? NODE_MAX : int'(node_limit);
    endfunction

    // Work out the messages one request causes and update the directory copy
    function automatic void predict_request(action_t act, logic [PAGE_W-1:0] pg,
                                            logic [NODE_W-1:0] rq);
        int                  active;
        logic [NODE_MAX-1:0] held;
        logic                have;
        int                  from;
        active = active_nodes();
        held   = dir_holders[pg];
        have   = 1'b0;
        from   = 0;
        if (int'(rq) >= active || act == ACT_BAD)
        begin
            add_expected(build_msg(MSG_REJECT, rq, pg, 1'b0, 0, 1'b0, 1'b1));
        end
        else if (act == ACT_WRITE)
        begin
            for (int i = 0; i < active; i++)
            begin
                if (i != int'(rq))
                begin
                    // first other holder supplies the data
                    if (!have && held[i])
                    begin
                        add_expected(build_msg(MSG_FETCH, i, pg, 1'b0, 0, 1'b0, 1'b0));
                        have = 1'b1;
                        from = i;
                    end
                    add_expected(build_msg(MSG_INVALIDATE, i, pg, 1'b0, 0, 1'b0, 1'b0));
                end
            end
            dir_holders[pg]     = '0;
            dir_holders[pg][rq] = 1'b1;
            dir_mode[pg]        = MODE_WRITABLE;
            add_expected(build_msg(MSG_GRANT, rq, pg, 1'b1, from, have, 1'b0));
            add_expected(build_msg(MSG_REPLY, rq, pg, 1'b0, from, have, 1'b1));
        end
        else if (act == ACT_READ)
        begin
            // first holder, requester included, is fetched or loses write access
            for (int i = 0; i < active; i++)
            begin
                if (!have && held[i])
                begin
                    add_expected(build_msg(
                        (dir_mode[pg] == MODE_SHARED) ? MSG_FETCH : MSG_REVOKE,
                        i, pg, 1'b0, 0, 1'b0, 1'b0));
                    have = 1'b1;
                    from = i;
                end
            end
            dir_holders[pg][rq] = 1'b1;
            dir_mode[pg]        = MODE_SHARED;
            add_expected(build_msg(MSG_REPLY, rq, pg, 1'b0, from, have, 1'b1));
        end
        else
        begin
            dir_holders[pg]     = '0;
            dir_holders[pg][rq] = 1'b1;
            dir_mode[pg]        = MODE_SHARED;
            add_expected(build_msg(MSG_GRANT, rq, pg, 1'b0, 0, 1'b0, 1'b1));
        end
    endfunction

    // Offer one request, wait for it to be taken, then idle between bursts unless the sender is steady
    task automatic send_request(input action_t act, input logic [PAGE_W-1:0] pg,
                                input logic [NODE_W-1:0] rq);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, rq, pg};
        s_axis_tuser  <= act;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_request(act, pg, rq);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (!sender_steady)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_msgs.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_node_count(input logic [NODE_CNT_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        node_limit = value;
    endtask

    // Compare one accepted message with the oldest expectation
    task automatic check_message();
        msg_t want;
        if (pending_msgs.size() == 0)
        begin
            report_mismatch($sformatf("unexpected message kind %0d target %0d page %0d",
                                      m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[13:4]));
            return;
        end
        want = pending_msgs.pop_front();
        if (m_axis_tuser !== want.kind)
            report_mismatch($sformatf("kind %0d, wanted %0d", m_axis_tuser, want.kind));
        if (m_axis_tdata[3:0] !== want.target_node)
            report_mismatch($sformatf("target %0d, wanted %0d", m_axis_tdata[3:0],
                                      want.target_node));
        if (m_axis_tdata[13:4] !== want.page_index)
            report_mismatch($sformatf("page %0d, wanted %0d", m_axis_tdata[13:4],
                                      want.page_index));
        if (m_axis_tdata[14] !== want.grants_write)
            report_mismatch($sformatf("grants_write %0b, wanted %0b", m_axis_tdata[14],
                                      want.grants_write));
        if (m_axis_tdata[18:15] !== want.data_from)
            report_mismatch($sformatf("data_from %0d, wanted %0d", m_axis_tdata[18:15],
                                      want.data_from));
        if (m_axis_tdata[19] !== want.data_valid)
            report_mismatch($sformatf("data_valid %0b, wanted %0b", m_axis_tdata[19],
                                      want.data_valid));
        if (m_axis_tlast !== want.last)
            report_mismatch($sformatf("last %0b, wanted %0b", m_axis_tlast, want.last));
    endtask

    // Message side: check at each handshake, then pick the next ready
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_message();
        if (holdoff_taken != holdoff_requested)
        begin
            holdoff_taken = holdoff_requested;
            holdoff_left  = holdoff_len;
        end
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                pattern_kind = rx_pattern_t'($urandom_range(0, 2));
                pattern_left = $urandom_range(4, 60);
            end
            pattern_left--;
            case (pattern_kind)
                RX_OPEN: m_axis_tready <= 1'b1;
                RX_HALF: m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Extremes of every field and each kind of request at full node count
    task automatic test_directed();
        send_request(ACT_CLAIM, 10'd0, 4'd0);
        send_request(ACT_READ, 10'd0, 4'd0);        // sole holder reads its own page
        send_request(ACT_READ, 10'd0, 4'd15);
        send_request(ACT_WRITE, 10'd0, 4'd15);      // fetch plus every invalidate
        send_request(ACT_READ, 10'd0, 4'd3);        // writer loses write access
        send_request(ACT_WRITE, 10'd1023, 4'd0);    // nobody holds it: no data
        send_request(ACT_WRITE, 10'd1023, 4'd0);    // only the requester holds it
        send_request(ACT_READ, 10'd1023, 4'd0);     // writer reads back its own copy
        send_request(ACT_READ, 10'd5, 4'd7);
        send_request(ACT_BAD, 10'h2AA, 4'd5);
        send_request(ACT_BAD, 10'h155, 4'd10);
        send_request(ACT_CLAIM, 10'h2AA, 4'd10);
        send_request(ACT_WRITE, 10'h2AA, 4'd5);
        send_request(ACT_READ, 10'h155, 4'd10);
        send_request(ACT_CLAIM, 10'd0, 4'd9);       // claim drops all sharers
    endtask

    // Requesters beyond the node count, a single node and an oversized count
    task automatic test_node_count_limits();
        set_node_count(5'd4);
        send_request(ACT_WRITE, 10'd0, 4'd4);
        send_request(ACT_READ, 10'd0, 4'd15);
        send_request(ACT_WRITE, 10'd0, 4'd3);       // holder 9 lies outside the scan
        send_request(ACT_READ, 10'd1023, 4'd3);
        set_node_count(5'd1);
        send_request(ACT_WRITE, 10'h155, 4'd0);
        send_request(ACT_READ, 10'h155, 4'd1);
        send_request(ACT_CLAIM, 10'h155, 4'd0);
        set_node_count(5'd31);                      // acts as the full node count
        send_request(ACT_WRITE, 10'd0, 4'd15);
        send_request(ACT_READ, 10'd0, 4'd0);
        set_node_count(5'd16);
    endtask

    // Long receiver hold-off while writes keep coming, so the input stalls
    task automatic test_backpressure();
        holdoff_len = 300;
        holdoff_requested++;
        sender_steady = 1'b1;
        repeat (20)
            send_request(ACT_WRITE, 10'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
        sender_steady = 1'b0;
    endtask

    // Mostly legal requests on a few hot pages, with some rejects mixed in
    task automatic send_random_request();
        action_t             act;
        logic [PAGE_W-1:0]   pg;
        logic [NODE_W-1:0]   rq;
        int                  active;
        int                  roll;
        active = active_nodes();
        roll   = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 85)
            pg = hot_pages[$urandom_range(0, HOT_PAGES - 1)];
        else
            pg = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
        rq = NODE_W'($urandom_range(0, active - 1));
        if (roll < 38)
            act = ACT_READ;
        else if (roll < 72)
            act = ACT_WRITE;
        else if (roll < 88)
            act = ACT_CLAIM;
        else if (roll < 94)
        begin
            act = ACT_BAD;
            rq  = NODE_W'($urandom_range(0, NODE_MAX - 1));
        end
        else
        begin
            act = action_t'($urandom_range(0, 2));
            if (active < NODE_MAX)
                rq = NODE_W'($urandom_range(active, NODE_MAX - 1));
        end
        send_request(act, pg, rq);
    endtask

    task automatic test_random_traffic();
        logic [NODE_CNT_W-1:0] counts [6];
        counts = '{5'd16, 5'd1, 5'd7, 5'd16, 5'd31, 5'd16};
        counts[5] = NODE_CNT_W'($urandom_range(2, 16));
        for (int phase = 0; phase < 6; phase++)
        begin
            set_node_count(counts[phase]);
            for (int i = 0; i < HOT_PAGES; i++)
                hot_pages[i] = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
            hot_pages[0] = (phase % 2 == 0) ? 10'd0 : 10'd1023;
            sender_steady = (phase == 3);
            repeat (55)
                send_random_request();
        end
        sender_steady = 1'b0;
    endtask

    initial
    begin
        for (int p = 0; p < PAGE_COUNT; p++)
        begin
            dir_holders[p] = '0;
            dir_mode[p]    = MODE_SHARED;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_node_count_limits();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
